/* design/akd_pkg.sv */
// Shared types and constants for the ladder keypad decoder.
`timescale 1ns / 1ps

package akd_pkg;

    localparam int SampleW = 12;
    localparam int LevelW  = 12;
    localparam int TolW    = 10;
    localparam int TicksW  = 8;
    localparam int KeyW    = 3;
    localparam int KindW   = 2;
    localparam int OffW    = 9;
    localparam int SumW    = 18;
    localparam int CountW  = 7;
    localparam int NumKeys = 5;
    localparam int NumRegs = 8;
    localparam int AddrW   = 5;

    localparam logic [SampleW-1:0] IdleLowMv  = 12'd2080;
    localparam logic [SampleW-1:0] IdleHighMv = 12'd2400;
    localparam logic [SumW-1:0]    SumMax     = {SumW{1'b1}};
    localparam logic [TicksW-1:0]  TicksMax   = {TicksW{1'b1}};

    localparam int ResDepth = 8;
    localparam int ResPtrW  = $clog2(ResDepth);
    localparam int ResCntW  = ResPtrW + 1;

    typedef enum logic [KindW-1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_TAP     = 2'd2,
        EV_LONG    = 2'd3
    } akd_kind_t;

    typedef enum logic [2:0] {
        REG_LEVEL_ONE   = 3'd0,
        REG_LEVEL_TWO   = 3'd1,
        REG_LEVEL_THREE = 3'd2,
        REG_LEVEL_FOUR  = 3'd3,
        REG_LEVEL_FIVE  = 3'd4,
        REG_TOLERANCE   = 3'd5,
        REG_IDLE_NOM    = 3'd6,
        REG_LONG_TICKS  = 3'd7
    } akd_reg_t;

    localparam logic [LevelW-1:0] RstLevelOne   = 12'd177;
    localparam logic [LevelW-1:0] RstLevelTwo   = 12'd505;
    localparam logic [LevelW-1:0] RstLevelThree = 12'd811;
    localparam logic [LevelW-1:0] RstLevelFour  = 12'd1115;
    localparam logic [LevelW-1:0] RstLevelFive  = 12'd1428;
    localparam logic [TolW-1:0]   RstTolerance  = 10'd100;
    localparam logic [LevelW-1:0] RstIdleNom    = 12'd2212;
    localparam logic [TicksW-1:0] RstLongTicks  = 8'd10;

    typedef struct packed {
        logic [NumKeys-1:0][LevelW-1:0] level;
        logic [TolW-1:0]                tolerance;
        logic [LevelW-1:0]              idle_nominal;
        logic [TicksW-1:0]              long_ticks;
    } akd_cfg_t;

    typedef struct packed {
        akd_kind_t       kind;
        logic [KeyW-1:0] key;
        logic            last;
    } akd_res_t;

    typedef struct packed {
        logic [1:0] count;
        akd_res_t   r0;
        akd_res_t   r1;
    } akd_push_t;

endpackage

/* design/akd_cfg_regs.sv */
// APB register file holding the key levels, tolerance, idle nominal and long threshold.
`timescale 1ns / 1ps

module akd_cfg_regs
    import akd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output akd_cfg_t         cfg
);

    akd_cfg_t   cfg_reg;
    logic       wr_en;
    akd_reg_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = akd_reg_t'(paddr[AddrW-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level[0]     <= RstLevelOne;
            cfg_reg.level[1]     <= RstLevelTwo;
            cfg_reg.level[2]     <= RstLevelThree;
            cfg_reg.level[3]     <= RstLevelFour;
            cfg_reg.level[4]     <= RstLevelFive;
            cfg_reg.tolerance    <= RstTolerance;
            cfg_reg.idle_nominal <= RstIdleNom;
            cfg_reg.long_ticks   <= RstLongTicks;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LEVEL_ONE:   cfg_reg.level[0]     <= pwdata[LevelW-1:0];
                REG_LEVEL_TWO:   cfg_reg.level[1]     <= pwdata[LevelW-1:0];
                REG_LEVEL_THREE: cfg_reg.level[2]     <= pwdata[LevelW-1:0];
                REG_LEVEL_FOUR:  cfg_reg.level[3]     <= pwdata[LevelW-1:0];
                REG_LEVEL_FIVE:  cfg_reg.level[4]     <= pwdata[LevelW-1:0];
                REG_TOLERANCE:   cfg_reg.tolerance    <= pwdata[TolW-1:0];
                REG_IDLE_NOM:    cfg_reg.idle_nominal <= pwdata[LevelW-1:0];
                REG_LONG_TICKS:  cfg_reg.long_ticks   <= pwdata[TicksW-1:0];
                default:         cfg_reg.long_ticks   <= cfg_reg.long_ticks;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LEVEL_ONE:   prdata = {20'd0, cfg_reg.level[0]};
            REG_LEVEL_TWO:   prdata = {20'd0, cfg_reg.level[1]};
            REG_LEVEL_THREE: prdata = {20'd0, cfg_reg.level[2]};
            REG_LEVEL_FOUR:  prdata = {20'd0, cfg_reg.level[3]};
            REG_LEVEL_FIVE:  prdata = {20'd0, cfg_reg.level[4]};
            REG_TOLERANCE:   prdata = {22'd0, cfg_reg.tolerance};
            REG_IDLE_NOM:    prdata = {20'd0, cfg_reg.idle_nominal};
            REG_LONG_TICKS:  prdata = {24'd0, cfg_reg.long_ticks};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* design/akd_decode.sv */
// Input register, key match, idle calibration and event generation.
`timescale 1ns / 1ps

module akd_decode
    import akd_pkg::*;
#(
    parameter int SHORT_TICKS        = 5,
    parameter int IDLE_AVERAGE_COUNT = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [SampleW-1:0] in_sample,
    input  akd_cfg_t           cfg,
    output logic               stage_valid,
    output akd_push_t          push
);

    // exact reciprocal for any sum below 2^SumW
    localparam int    DivShift = SumW + $clog2(IDLE_AVERAGE_COUNT);
    localparam longint Recip   = ((64'd1 << DivShift) + IDLE_AVERAGE_COUNT - 1)
                                 / IDLE_AVERAGE_COUNT;
    localparam int    RecipW   = SumW + 2;
    localparam int    ProdW    = SumW + RecipW;
    localparam int    CmpW     = 14;

    logic               valid_reg;
    logic [SampleW-1:0] sample_reg;

    logic [CountW-1:0]     idle_count_reg, idle_count_next;
    logic [SumW-1:0]       idle_sum_reg, idle_sum_next;
    logic signed [OffW-1:0] offset_reg, offset_next;
    logic [KeyW-1:0]       last_key_reg, last_key_next;
    logic [TicksW-1:0]     hold_reg, hold_next;
    logic                  fired_reg, fired_next;

    logic                  is_idle;
    logic [KeyW-1:0]       curr;
    logic [NumKeys-1:0]    hit;
    logic signed [CmpW-1:0] s_cmp;
    logic signed [CmpW-1:0] ctr [NumKeys];
    logic signed [CmpW-1:0] tol_s;
    logic [CountW-1:0]     cnt1;
    logic [SumW:0]         sum_wide;
    logic [SumW-1:0]       sum_sat;
    logic [ProdW-1:0]      prod;
    logic [SumW-1:0]       avg;
    logic signed [SumW+1:0] diff;
    logic [TicksW-1:0]     h1;
    logic                  long_ok;
    akd_push_t             push_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            idle_count_reg <= '0;
            idle_sum_reg   <= '0;
            offset_reg     <= '0;
            last_key_reg   <= '0;
            hold_reg       <= '0;
            fired_reg      <= 1'b0;
        end
        else
        begin
            valid_reg      <= in_valid;
            idle_count_reg <= idle_count_next;
            idle_sum_reg   <= idle_sum_next;
            offset_reg     <= offset_next;
            last_key_reg   <= last_key_next;
            hold_reg       <= hold_next;
            fired_reg      <= fired_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sample_reg <= in_sample;
        end
    end

    assign stage_valid = valid_reg;
    assign push        = push_c;

    assign is_idle = (sample_reg >= IdleLowMv) && (sample_reg <= IdleHighMv);
    assign s_cmp   = $signed({{(CmpW-SampleW){1'b0}}, sample_reg});
    assign tol_s   = $signed({{(CmpW-TolW){1'b0}}, cfg.tolerance});

    always_comb
    begin
        for (int k = 0; k < NumKeys; k++)
        begin
            ctr[k] = $signed({{(CmpW-LevelW){1'b0}}, cfg.level[k]})
                   + CmpW'(offset_reg);
            hit[k] = (s_cmp >= ctr[k] - tol_s) && (s_cmp <= ctr[k] + tol_s);
        end
    end

    always_comb
    begin
        curr = '0;
        for (int k = NumKeys - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                curr = KeyW'(k + 1);
            end
        end
    end

    // idle averaging
    assign cnt1     = idle_count_reg + 1'b1;
    assign sum_wide = {1'b0, idle_sum_reg} + (SumW + 1)'(sample_reg);
    assign sum_sat  = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
    assign prod     = ProdW'(sum_sat) * ProdW'(RecipW'(Recip));
    assign avg      = SumW'(prod >> DivShift);
    assign diff     = $signed({2'b00, avg}) - $signed({{(SumW+2-LevelW){1'b0}}, cfg.idle_nominal});

    assign h1      = (hold_reg < TicksMax) ? hold_reg + 1'b1 : hold_reg;
    assign long_ok = (h1 >= cfg.long_ticks) && !fired_reg;

    always_comb
    begin
        idle_count_next = idle_count_reg;
        idle_sum_next   = idle_sum_reg;
        offset_next     = offset_reg;
        last_key_next   = last_key_reg;
        hold_next       = hold_reg;
        fired_next      = fired_reg;
        push_c          = '0;
        push_c.r0.key   = last_key_reg;
        push_c.r1.key   = last_key_reg;

        if (valid_reg && is_idle)
        begin
            idle_count_next = cnt1;
            idle_sum_next   = sum_sat;
            if (cnt1 == CountW'(IDLE_AVERAGE_COUNT))
            begin
                idle_count_next = '0;
                idle_sum_next   = '0;
                if (diff > 255)
                    offset_next = 9'sd255;
                else if (diff < -256)
                    offset_next = -9'sd256;
                else
                    offset_next = OffW'(diff);
            end
        end

        if (valid_reg && (is_idle || (curr != '0)))
        begin
            hold_next = h1;
            if (is_idle ? (last_key_reg == '0) : (curr == last_key_reg))
            begin
                if (!is_idle && long_ok)
                begin
                    push_c.count   = 2'd1;
                    push_c.r0.kind = EV_LONG;
                    push_c.r0.last = 1'b1;
                    fired_next     = 1'b1;
                end
            end
            else
            begin
                hold_next = '0;
                if (is_idle)
                begin
                    last_key_next  = '0;
                    fired_next     = 1'b0;
                    push_c.r0.kind = EV_RELEASE;
                    if (h1 <= TicksW'(SHORT_TICKS))
                    begin
                        push_c.count   = 2'd2;
                        push_c.r1.kind = EV_TAP;
                        push_c.r1.last = 1'b1;
                    end
                    else if (long_ok)
                    begin
                        push_c.count   = 2'd2;
                        push_c.r1.kind = EV_LONG;
                        push_c.r1.last = 1'b1;
                    end
                    else
                    begin
                        push_c.count   = 2'd1;
                        push_c.r0.last = 1'b1;
                    end
                end
                else
                begin
                    last_key_next  = curr;
                    push_c.count   = 2'd1;
                    push_c.r0.kind = EV_PRESS;
                    push_c.r0.key  = curr;
                    push_c.r0.last = 1'b1;
                end
            end
        end
    end

endmodule

/* design/akd_res_fifo.sv */
// Result queue taking up to two events per cycle and releasing one per cycle while popped.
`timescale 1ns / 1ps

module akd_res_fifo
    import akd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  akd_push_t          push,
    input  logic               pop,
    output logic               not_empty,
    output akd_res_t           head,
    output logic [ResCntW-1:0] count
);

    akd_res_t           mem [ResDepth];
    logic [ResPtrW-1:0] wptr_reg, rptr_reg;
    logic [ResCntW-1:0] count_reg;
    logic               do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem[rptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + ResPtrW'(push.count);
            rptr_reg  <= rptr_reg + ResPtrW'(do_pop);
            count_reg <= count_reg + ResCntW'(push.count) - ResCntW'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem[wptr_reg + 1'b1] <= push.r1;
        end
    end

endmodule

/* design/adc_ladder_key_decoder.sv */
// Top level of the five-key resistor ladder keypad decoder.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata[11:0] sample_mv
//  m_*       out  m_tvalid/m_tready    m_tdata[1:0] event_kind, [4:2] key_index; m_tlast
//  apb       in   psel/penable         paddr, pwdata, prdata; pready tied high
//
// One sample per cycle while s_tready is high: registered, decoded combinationally, events queued.
// The events of an item pass the input register and then the queue count register before m_tvalid.
// Each sample makes 0..2 events; the eight-entry queue and its single-event
// output port set the sustained rate when many samples produce events.
// s_tready drops unless the queue has room for two events of the staged
// sample and two of a new one.
// Asynchronous active-low reset restores register defaults and clears state.
`timescale 1ns / 1ps

module adc_ladder_key_decoder
    import akd_pkg::*;
#(
    parameter int SHORT_TICKS        = 5,
    parameter int IDLE_AVERAGE_COUNT = 100
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [11:0] sample_mv
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [1:0] event_kind, [4:2] key_index
    output logic             m_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    akd_cfg_t           cfg;
    akd_push_t          push;
    akd_res_t           head;
    logic               stage_valid;
    logic [ResCntW-1:0] q_count;
    logic [ResCntW:0]   q_need;

    assign q_need   = {1'b0, q_count} + (stage_valid ? (ResCntW + 1)'(2) : '0);
    assign s_tready = (q_need <= (ResCntW + 1)'(ResDepth - 2));

    akd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    akd_decode #(
        .SHORT_TICKS        (SHORT_TICKS),
        .IDLE_AVERAGE_COUNT (IDLE_AVERAGE_COUNT)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid && s_tready),
        .in_sample   (s_tdata[SampleW-1:0]),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .push        (push)
    );

    akd_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (q_count)
    );

    assign m_tdata = {3'b000, head.key, head.kind};
    assign m_tlast = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ResCntW'(ResDepth))
        else $error("result queue overflow");

    a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid |-> (q_count <= ResCntW'(ResDepth - 2)))
        else $error("no room for events of staged sample");

    a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> stage_valid)
        else $error("accepted sample not staged");

    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid |-> (push.count == 2'd0))
        else $error("events without a staged sample");

endmodule
